>>> hw/rtl/ttip_pkg.sv
// Shared types and constants for the text-to-integer parser.
// Used by every module of the block; depends on nothing.

package ttip_pkg;

  localparam int ACC_W     = 64;
  localparam int BASE_W    = 6;
  localparam int CONS_W    = 12;
  localparam int MAX_COUNT = 4095;
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int MAC_W     = ACC_W + BASE_W + 1;

  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = BASE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 1'd1;

  localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO   = 6'd0;
  localparam logic [BASE_W-1:0] BASE_BIN    = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX    = 6'd36;
  localparam logic [BASE_W-1:0] NO_DIGIT    = '1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  localparam logic [ACC_W-1:0] UINT_MAX_V = '1;
  localparam logic [ACC_W-1:0] INT_MAX_V  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] INT_MIN_V  = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [ACC_W-1:0]  value;
    logic              overflow;
    logic [CONS_W-1:0] consumed;
  } out_item_t;

  // One character after classification.
  typedef struct packed {
    logic              start;
    logic              is_space;
    logic              is_sign;
    logic              is_minus;
    logic              is_zero;
    logic              is_x;
    logic              is_b;
    logic [BASE_W-1:0] dval;
  } cls_t;

  typedef struct packed {
    logic [BASE_W-1:0] radix;
    logic              signed_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS
  } phase_t;

endpackage

>>> hw/rtl/ttip_front.sv
// Front end: accepts characters and classifies them for the back end.
// Depends on ttip_pkg; feeds ttip_fifo.

module ttip_front (
  input  logic              in_valid,
  input  ttip_pkg::in_item_t in_data,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output ttip_pkg::cls_t    q_wdata
);

  logic [7:0] ch;

  assign ch       = in_data.ch;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.start    = in_data.start_req;
    q_wdata.is_space = (ch inside {ttip_pkg::CH_SPACE, [ttip_pkg::CH_TAB:ttip_pkg::CH_CR]});
    q_wdata.is_sign  = (ch == ttip_pkg::CH_PLUS) || (ch == ttip_pkg::CH_MINUS);
    q_wdata.is_minus = (ch == ttip_pkg::CH_MINUS);
    q_wdata.is_zero  = (ch == ttip_pkg::CH_ZERO);
    q_wdata.is_x     = (ch == ttip_pkg::CH_LX) || (ch == ttip_pkg::CH_UX);
    q_wdata.is_b     = (ch == ttip_pkg::CH_LB) || (ch == ttip_pkg::CH_UB);
    if (ch inside {[ttip_pkg::CH_ZERO:ttip_pkg::CH_NINE]}) begin
      q_wdata.dval = ttip_pkg::BASE_W'(ch - ttip_pkg::CH_ZERO);
    end else if (ch inside {[ttip_pkg::CH_LA:ttip_pkg::CH_LZ]}) begin
      q_wdata.dval = ttip_pkg::BASE_W'(ch - ttip_pkg::CH_LA + ttip_pkg::LETTER_OFS);
    end else if (ch inside {[ttip_pkg::CH_UA:ttip_pkg::CH_UZ]}) begin
      q_wdata.dval = ttip_pkg::BASE_W'(ch - ttip_pkg::CH_UA + ttip_pkg::LETTER_OFS);
    end else begin
      q_wdata.dval = ttip_pkg::NO_DIGIT;
    end
  end

endmodule

>>> hw/rtl/ttip_fifo.sv
// Short queue of classified characters between front and back end.
// Depends on ttip_pkg.

module ttip_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttip_pkg::cls_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output ttip_pkg::cls_t rdata
);

  ttip_pkg::cls_t                 mem_r [ttip_pkg::Q_DEPTH];
  logic [ttip_pkg::Q_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ttip_pkg::Q_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ttip_pkg::Q_CW-1:0]      count_r, count_nxt;

  assign full  = (count_r == ttip_pkg::Q_CW'(ttip_pkg::Q_DEPTH));
  assign valid = (count_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ttip_pkg::Q_AW'(ttip_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ttip_pkg::Q_AW'(ttip_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> hw/rtl/ttip_back.sv
// Back end: conversion state machine, multiply-accumulate and result register.
// Depends on ttip_pkg; reads classified characters from ttip_fifo.

module ttip_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ttip_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  ttip_pkg::cls_t      q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ttip_pkg::out_item_t out_data
);

  ttip_pkg::phase_t                phase_r, phase_nxt, ph_e;
  logic [ttip_pkg::ACC_W-1:0]      acc_r, acc_nxt, acc_e;
  logic                            neg_r, neg_nxt, neg_e;
  logic [ttip_pkg::BASE_W-1:0]     base_r, base_nxt, base_e;
  logic [ttip_pkg::CNT_W-1:0]      cnt_r, cnt_nxt, cnt_e, fin_cnt;
  logic                            ovf_r, ovf_nxt, ovf_e;
  logic                            out_valid_r, out_valid_nxt;
  ttip_pkg::out_item_t             out_data_r, out_data_nxt;

  ttip_pkg::cls_t                  it;
  logic                            pop;
  logic                            bump, go_signed, go_zero, go_prefix, do_take, tk_got, pfx_fin;
  logic [ttip_pkg::BASE_W-1:0]     pfx_base, tk_base;
  logic                            digit_ok, take_dig, fin;
  logic                            base_auto, base_bin, base_hex;
  logic [ttip_pkg::MAC_W-1:0]      mac;
  logic                            mac_ovf;
  logic [ttip_pkg::ACC_W-1:0]      res_value;
  logic                            res_ovf;

  assign it    = q_rdata;
  assign pop   = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = pop;

  // A start flag restarts the conversion with this very character.
  assign ph_e   = it.start ? ttip_pkg::PH_SPACE : phase_r;
  assign acc_e  = it.start ? '0 : acc_r;
  assign neg_e  = it.start ? 1'b0 : neg_r;
  assign base_e = it.start ? cfg.radix : base_r;
  assign cnt_e  = it.start ? '0 : cnt_r;
  assign ovf_e  = it.start ? 1'b0 : ovf_r;

  assign base_auto = (base_e == ttip_pkg::BASE_AUTO);
  assign base_bin  = (base_e == ttip_pkg::BASE_BIN);
  assign base_hex  = (base_e == ttip_pkg::BASE_HEX);

  // Decode what this character does in the current phase.
  always_comb begin
    bump      = 1'b0;
    go_signed = 1'b0;
    go_zero   = 1'b0;
    go_prefix = 1'b0;
    pfx_base  = base_e;
    do_take   = 1'b0;
    tk_base   = base_e;
    tk_got    = 1'b0;
    pfx_fin   = 1'b0;
    case (ph_e)
      ttip_pkg::PH_SPACE, ttip_pkg::PH_SIGNED: begin
        if ((ph_e == ttip_pkg::PH_SPACE) && it.is_space) begin
          bump = 1'b1;
        end else if ((ph_e == ttip_pkg::PH_SPACE) && it.is_sign) begin
          bump      = 1'b1;
          go_signed = 1'b1;
        end else if (it.is_zero && (base_auto || base_bin || base_hex)) begin
          bump    = 1'b1;
          go_zero = 1'b1;
        end else begin
          do_take = 1'b1;
          tk_base = base_auto ? ttip_pkg::BASE_DEC : base_e;
        end
      end
      ttip_pkg::PH_ZERO: begin
        if ((base_auto || base_hex) && it.is_x) begin
          bump      = 1'b1;
          go_prefix = 1'b1;
          pfx_base  = ttip_pkg::BASE_HEX;
        end else if ((base_auto || base_bin) && it.is_b) begin
          bump      = 1'b1;
          go_prefix = 1'b1;
          pfx_base  = ttip_pkg::BASE_BIN;
        end else begin
          do_take = 1'b1;
          tk_got  = 1'b1;
          tk_base = base_auto ? ttip_pkg::BASE_OCT : base_e;
        end
      end
      ttip_pkg::PH_PREFIX: begin
        do_take = 1'b1;
        tk_got  = 1'b1;
        pfx_fin = 1'b1;
      end
      ttip_pkg::PH_DIGITS: begin
        do_take = 1'b1;
        tk_got  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign digit_ok = (tk_base >= ttip_pkg::BASE_BIN) && (tk_base <= ttip_pkg::BASE_MAX) &&
                    (it.dval < tk_base);
  assign take_dig = do_take && digit_ok;
  assign fin      = do_take && !digit_ok;

  // One narrow multiply by the base plus the digit; a carry out of 64 bits is overflow.
  assign mac     = ttip_pkg::MAC_W'(acc_e) * ttip_pkg::MAC_W'(tk_base) +
                   ttip_pkg::MAC_W'(it.dval);
  assign mac_ovf = (mac[ttip_pkg::MAC_W-1:ttip_pkg::ACC_W] != '0);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (pop) begin
      if (fin) begin
        phase_nxt = ttip_pkg::PH_IDLE;
      end else if (take_dig) begin
        phase_nxt = ttip_pkg::PH_DIGITS;
      end else if (go_prefix) begin
        phase_nxt = ttip_pkg::PH_PREFIX;
      end else if (go_zero) begin
        phase_nxt = ttip_pkg::PH_ZERO;
      end else if (go_signed) begin
        phase_nxt = ttip_pkg::PH_SIGNED;
      end else begin
        phase_nxt = ph_e;
      end
    end
  end

  // Result value, with saturation on overflow.
  always_comb begin
    fin_cnt   = pfx_fin ? cnt_e - 1'b1 : cnt_e;
    res_value = '0;
    res_ovf   = 1'b0;
    if (!cfg.signed_mode) begin
      if (ovf_e) begin
        res_value = ttip_pkg::UINT_MAX_V;
        res_ovf   = 1'b1;
      end else begin
        res_value = neg_e ? '0 - acc_e : acc_e;
      end
    end else if (!neg_e) begin
      if (ovf_e || acc_e[ttip_pkg::ACC_W-1]) begin
        res_value = ttip_pkg::INT_MAX_V;
        res_ovf   = 1'b1;
      end else begin
        res_value = acc_e;
      end
    end else begin
      if (ovf_e || (acc_e > ttip_pkg::INT_MIN_V)) begin
        res_value = ttip_pkg::INT_MIN_V;
        res_ovf   = 1'b1;
      end else begin
        res_value = '0 - acc_e;
      end
    end
  end

  // Datapath and result register.
  always_comb begin
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (pop) begin
      acc_nxt  = (take_dig && !ovf_e && !mac_ovf) ? mac[ttip_pkg::ACC_W-1:0] : acc_e;
      ovf_nxt  = ovf_e || (take_dig && mac_ovf);
      neg_nxt  = go_signed ? it.is_minus : neg_e;
      base_nxt = go_prefix ? pfx_base : (do_take ? tk_base : base_e);
      cnt_nxt  = ((bump || take_dig) && (cnt_e < ttip_pkg::CNT_W'(ttip_pkg::MAX_COUNT))) ?
                 cnt_e + 1'b1 : cnt_e;
      if (fin) begin
        out_valid_nxt = 1'b1;
        if (tk_got) begin
          out_data_nxt.value    = res_value;
          out_data_nxt.overflow = res_ovf;
          out_data_nxt.consumed = ttip_pkg::CONS_W'(fin_cnt);
        end else begin
          out_data_nxt.value    = '0;
          out_data_nxt.overflow = 1'b0;
          out_data_nxt.consumed = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ttip_pkg::PH_IDLE;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      base_r      <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/text_to_integer_parser.sv
// Top level of the streaming text-to-integer parser.
// Depends on ttip_pkg, ttip_front, ttip_fifo and ttip_back.

// The parser takes one character per input beat and converts a string to a
// 64-bit integer, the way strtoumax and strtoimax do. A beat with start_req set
// begins a new conversion with its character; a conversion that is still open
// is then dropped without a result. Leading whitespace, one sign and the "0x",
// "0b" and leading-zero prefixes are handled, and radix 0 picks the base from
// the prefix. The first character that cannot continue the number closes the
// conversion and yields exactly one result beat: the value, an overflow flag
// and the count of characters consumed (zero, with value zero, when no number
// was found). Overflow saturates; in signed mode the limits are those of a
// 64-bit two's-complement integer. The block sustains one character per clock
// while nothing stalls: the front end classifies a character and drops it into
// a two-entry queue, and the back end consumes one entry per cycle, with a
// single 64-by-6-bit multiply-add by the base per digit setting that pace.
// The result of a closing character passes from the queue into the result
// register, from which it shows on the output. The back end waits only
// when its result register holds a beat that is stalled, and the input waits
// only when the queue is full. The radix is sampled when a conversion starts
// and signed_mode when its result is made; configuration is meant to be
// written while the block is idle.

module text_to_integer_parser (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ttip_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ttip_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [ttip_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ttip_pkg::CFG_DW-1:0]          cfg_wdata
);

  // Configuration registers.
  ttip_pkg::cfg_t cfg_r, cfg_nxt;

  // Queue between front and back end.
  logic           q_push, q_full, q_pop, q_valid;
  ttip_pkg::cls_t q_wdata, q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ttip_pkg::CFG_RADIX:  cfg_nxt.radix       = cfg_wdata;
        ttip_pkg::CFG_SIGNED: cfg_nxt.signed_mode = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radix       <= ttip_pkg::RADIX_RESET;
      cfg_r.signed_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end classifies each character as it is accepted.
  ttip_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // The queue lets the input keep flowing while a result waits downstream.
  ttip_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // The back end runs the conversion and holds the result beat.
  ttip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/ttip_checker.sv
// Port-level checks for the text-to-integer parser, bound to its top level.
// Depends on ttip_pkg and text_to_integer_parser.

module ttip_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input ttip_pkg::out_item_t            out_data
);

  // A stalled result beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // An overflowed result always carries one of the saturation values.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |->
      (out_data.value == ttip_pkg::UINT_MAX_V) || (out_data.value == ttip_pkg::INT_MAX_V) ||
      (out_data.value == ttip_pkg::INT_MIN_V))
    else $error("overflow without a saturated value");

  // When nothing was consumed, no number was found and the result is zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.consumed == '0) |->
      (out_data.value == '0) && !out_data.overflow)
    else $error("empty conversion with a nonzero result");

  // Result beats need a character to close them: none appears right after reset
  // before any input beat has been accepted.
  a_no_early_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat out of reset");

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker (.*);

>>> tb/tb_text_to_integer_parser.sv
// Self-checking testbench for the streaming text-to-integer parser.
// Depends on ttip_pkg and text_to_integer_parser, and through it on the rest of the block.
// A local model predicts every result and a monitor compares each output beat.

module tb_text_to_integer_parser;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let pass after the last expected result before touching the
  // configuration or ending. Output trails its closing character via the queue and
  // result register, and up to two characters that close nothing may sit in the queue.
  localparam int LATENCY_SLACK = 8;

  logic                out_valid;
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ttip_pkg::in_item_t  in_data = '0;
  logic                out_stall = 1'b0;
  ttip_pkg::out_item_t out_data;
  logic                                 cfg_we = 1'b0;
  logic [ttip_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [ttip_pkg::CFG_DW-1:0]          cfg_wdata = '0;

  text_to_integer_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Conversion model. It mirrors the parser's state: the configuration as last
  // written, the phase of the conversion, the magnitude gathered so far, the
  // sign, the base in force, the characters counted and the overflow flag.
  // ---------------------------------------------------------------------------
  logic [ttip_pkg::BASE_W-1:0] radix_q = ttip_pkg::RADIX_RESET;
  logic                        signed_q = 1'b0;
  ttip_pkg::phase_t            cur_phase = ttip_pkg::PH_IDLE;
  logic [ttip_pkg::ACC_W-1:0]  acc = '0;
  logic                        acc_neg = 1'b0;
  logic [ttip_pkg::BASE_W-1:0] cur_base = '0;
  int                          char_cnt = 0;
  logic                        acc_ovf = 1'b0;

  ttip_pkg::out_item_t expected_results[$];
  int        live_beats = 0;   // beats that the parser did not simply drop
  int        mismatches = 0;

  // Value of a character as a digit in any base up to 36, either case.
  function automatic logic [ttip_pkg::BASE_W-1:0] digit_val(input logic [7:0] c);
    if (c >= ttip_pkg::CH_ZERO && c <= ttip_pkg::CH_NINE) begin
      return ttip_pkg::BASE_W'(c - ttip_pkg::CH_ZERO);
    end
    if (c >= ttip_pkg::CH_LA && c <= ttip_pkg::CH_LZ) begin
      return ttip_pkg::BASE_W'(c - ttip_pkg::CH_LA + ttip_pkg::LETTER_OFS);
    end
    if (c >= ttip_pkg::CH_UA && c <= ttip_pkg::CH_UZ) begin
      return ttip_pkg::BASE_W'(c - ttip_pkg::CH_UA + ttip_pkg::LETTER_OFS);
    end
    return ttip_pkg::NO_DIGIT;
  endfunction

  function automatic bit takes_digit(input logic [7:0] c);
    return cur_base >= ttip_pkg::BASE_BIN && cur_base <= ttip_pkg::BASE_MAX &&
           digit_val(c) < cur_base;
  endfunction

  function automatic void count_char();
    if (char_cnt < ttip_pkg::MAX_COUNT) char_cnt++;
  endfunction

  // Close the conversion. Without a number the result is all zero; otherwise
  // the magnitude is saturated or negated as the signed mode demands.
  function automatic void emit_result(input bit got, input int n);
    ttip_pkg::out_item_t r;
    r = '0;
    if (got) begin
      if (!signed_q) begin
        if (acc_ovf) begin
          r.value = ttip_pkg::UINT_MAX_V;
          r.overflow = 1'b1;
        end else begin
          r.value = acc_neg ? -acc : acc;
        end
      end else if (!acc_neg) begin
        if (acc_ovf || acc > ttip_pkg::INT_MAX_V) begin
          r.value = ttip_pkg::INT_MAX_V;
          r.overflow = 1'b1;
        end else begin
          r.value = acc;
        end
      end else begin
        if (acc_ovf || acc > ttip_pkg::INT_MIN_V) begin
          r.value = ttip_pkg::INT_MIN_V;
          r.overflow = 1'b1;
        end else begin
          r.value = -acc;
        end
      end
      r.consumed = n[ttip_pkg::CONS_W-1:0];
    end
    expected_results.push_back(r);
    cur_phase = ttip_pkg::PH_IDLE;
  endfunction

  // Add a digit to the magnitude, or close the conversion on a non-digit.
  // Once the magnitude has overflowed it is frozen, but digits still count.
  function automatic void digit_or_close(input logic [7:0] c, input bit got);
    logic [ttip_pkg::MAC_W-1:0] prod;
    if (takes_digit(c)) begin
      if (!acc_ovf) begin
        // Wide enough that the carry out of 64 bits is kept.
        prod = ttip_pkg::MAC_W'(acc) * ttip_pkg::MAC_W'(cur_base) +
               ttip_pkg::MAC_W'(digit_val(c));
        if (prod[ttip_pkg::MAC_W-1:ttip_pkg::ACC_W] != '0) acc_ovf = 1'b1;
        else acc = prod[ttip_pkg::ACC_W-1:0];
      end
      count_char();
      cur_phase = ttip_pkg::PH_DIGITS;
    end else begin
      emit_result(got, char_cnt);
    end
  endfunction

  // First character after whitespace and sign: a zero may open a prefix.
  function automatic void first_char(input logic [7:0] c);
    if (c == ttip_pkg::CH_ZERO && (cur_base == ttip_pkg::BASE_AUTO ||
                                   cur_base == ttip_pkg::BASE_BIN ||
                                   cur_base == ttip_pkg::BASE_HEX)) begin
      count_char();
      cur_phase = ttip_pkg::PH_ZERO;
    end else begin
      if (cur_base == ttip_pkg::BASE_AUTO) cur_base = ttip_pkg::BASE_DEC;
      digit_or_close(c, 1'b0);
    end
  endfunction

  function automatic void predict_beat(input ttip_pkg::in_item_t it);
    logic [7:0] c;
    c = it.ch;
    // A character without start while idle is dropped by the parser.
    if (!it.start_req && cur_phase == ttip_pkg::PH_IDLE) return;
    live_beats++;
    if (it.start_req) begin
      cur_phase = ttip_pkg::PH_SPACE;
      acc = '0;
      acc_neg = 1'b0;
      cur_base = radix_q;
      char_cnt = 0;
      acc_ovf = 1'b0;
    end
    case (cur_phase)
      ttip_pkg::PH_SPACE: begin
        if (c == ttip_pkg::CH_SPACE || (c >= ttip_pkg::CH_TAB && c <= ttip_pkg::CH_CR)) begin
          count_char();
        end else if (c == ttip_pkg::CH_PLUS || c == ttip_pkg::CH_MINUS) begin
          acc_neg = (c == ttip_pkg::CH_MINUS);
          count_char();
          cur_phase = ttip_pkg::PH_SIGNED;
        end else begin
          first_char(c);
        end
      end
      ttip_pkg::PH_SIGNED: first_char(c);
      ttip_pkg::PH_ZERO: begin
        if ((cur_base == ttip_pkg::BASE_AUTO || cur_base == ttip_pkg::BASE_HEX) &&
            (c == ttip_pkg::CH_LX || c == ttip_pkg::CH_UX)) begin
          cur_base = ttip_pkg::BASE_HEX;
          count_char();
          cur_phase = ttip_pkg::PH_PREFIX;
        end else if ((cur_base == ttip_pkg::BASE_AUTO || cur_base == ttip_pkg::BASE_BIN) &&
                     (c == ttip_pkg::CH_LB || c == ttip_pkg::CH_UB)) begin
          cur_base = ttip_pkg::BASE_BIN;
          count_char();
          cur_phase = ttip_pkg::PH_PREFIX;
        end else begin
          if (cur_base == ttip_pkg::BASE_AUTO) cur_base = ttip_pkg::BASE_OCT;
          digit_or_close(c, 1'b1);
        end
      end
      // A prefix with no digit behind it is the number zero, and the
      // letter of the prefix is not counted.
      ttip_pkg::PH_PREFIX: begin
        if (takes_digit(c)) digit_or_close(c, 1'b1);
        else emit_result(1'b1, char_cnt - 1);
      end
      ttip_pkg::PH_DIGITS: digit_or_close(c, 1'b1);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result monitor. Handshake signals are read at the rising edge, before any
  // nonblocking update of that edge, so the order of processes does not matter.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ttip_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%t: unexpected result beat: value %h overflow %b consumed %0d",
                 $time, out_data.value, out_data.overflow, out_data.consumed);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.value !== want.value) begin
          $display("%t: value mismatch: expected %h, actual %h",
                   $time, want.value, out_data.value);
          mismatches++;
        end
        if (out_data.overflow !== want.overflow) begin
          $display("%t: overflow mismatch: expected %b, actual %b",
                   $time, want.overflow, out_data.overflow);
          mismatches++;
        end
        if (out_data.consumed !== want.consumed) begin
          $display("%t: consumed mismatch: expected %0d, actual %0d",
                   $time, want.consumed, out_data.consumed);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure. After each random-length run the receiver switches to a
  // new behavior: never stalling, light or heavy random stalls, or a regular
  // pattern, so that stalls land on every phase of a conversion.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= int'($urandom_range(0, 3));
      stall_left <= int'($urandom_range(50, 400));
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      3:       out_stall <= stall_left[2];
      default: out_stall <= 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender. Beats go out in bursts of random length; between bursts the valid
  // drops for a random gap, sometimes none at all.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_beat(input logic [7:0] c, input bit first);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(30, 80))
                                               : int'($urandom_range(1, 16));
      gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 5));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{ch: c, start_req: first};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat('{ch: c, start_req: first});
  endtask

  // Sends a string as one conversion, then a character to close it.
  task automatic send_text(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == 0);
    send_beat(term, 1'b0);
  endtask

  // Holds the input back until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic settle();
    if (cur_phase != ttip_pkg::PH_IDLE) send_beat(8'h00, 1'b0);
    wait_drained();
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ttip_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ttip_pkg::CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ttip_pkg::CFG_RADIX) radix_q = val;
    else signed_q = val[0];
  endtask

  // Changes both registers once the parser has gone quiet.
  task automatic set_mode(input logic [ttip_pkg::BASE_W-1:0] rdx, input logic sgn);
    settle();
    write_reg(ttip_pkg::CFG_RADIX, rdx);
    write_reg(ttip_pkg::CFG_SIGNED, {{(ttip_pkg::CFG_DW-1){1'b0}}, sgn});
  endtask

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return ttip_pkg::CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? ttip_pkg::CH_LA : ttip_pkg::CH_UA) + 8'(d - 10);
  endfunction

  // One well-formed conversion with random content: optional whitespace and
  // sign, a prefix where the base allows one, a magnitude drawn near the
  // interesting limits, sometimes extra digits to force overflow, and a
  // closing non-digit. A few are left broken: no digits, or no closing
  // character so that the next start drops them.
  task automatic send_number();
    logic [7:0]                 txt[$];
    logic [7:0]                 digs[$];
    logic [ttip_pkg::ACC_W-1:0] mag;
    logic [7:0]                 c;
    int                         b;
    int                         n;
    n = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0;
    repeat (n) begin
      c = ($urandom_range(0, 5) == 0) ? ttip_pkg::CH_SPACE : 8'($urandom_range(9, 13));
      txt.push_back(c);
    end
    case ($urandom_range(0, 3))
      0: txt.push_back(ttip_pkg::CH_PLUS);
      1: txt.push_back(ttip_pkg::CH_MINUS);
      default: ;
    endcase
    b = int'(radix_q);
    if (radix_q == ttip_pkg::BASE_AUTO) begin
      case ($urandom_range(0, 3))
        0: begin
          txt.push_back(ttip_pkg::CH_ZERO);
          txt.push_back($urandom_range(0, 1) ? ttip_pkg::CH_LX : ttip_pkg::CH_UX);
          b = 16;
        end
        1: begin
          txt.push_back(ttip_pkg::CH_ZERO);
          txt.push_back($urandom_range(0, 1) ? ttip_pkg::CH_LB : ttip_pkg::CH_UB);
          b = 2;
        end
        2: begin
          txt.push_back(ttip_pkg::CH_ZERO);
          b = 8;
        end
        default: b = 10;
      endcase
    end else if ((radix_q == ttip_pkg::BASE_HEX || radix_q == ttip_pkg::BASE_BIN) &&
                 $urandom_range(0, 1)) begin
      txt.push_back(ttip_pkg::CH_ZERO);
      txt.push_back(radix_q == ttip_pkg::BASE_HEX ? ttip_pkg::CH_UX : ttip_pkg::CH_LB);
    end
    // Bases that accept no digit still get decimal text to reject.
    if (b < 2 || b > 36) b = 10;
    if ($urandom_range(0, 9) != 0) begin
      case ($urandom_range(0, 5))
        0: mag = 64'($urandom_range(0, 999));
        1: mag = {$urandom, $urandom};
        2: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
        3: mag = ttip_pkg::INT_MAX_V - 64'(2) + 64'($urandom_range(0, 4));
        4: mag = ttip_pkg::UINT_MAX_V - 64'($urandom_range(0, 3));
        default: mag = '0;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) txt.push_back(ttip_pkg::CH_ZERO);
      end
      do begin
        digs.push_front(digit_char(int'(mag % 64'(b))));
        mag = mag / 64'(b);
      end while (mag != 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          digs.push_back(digit_char(int'($urandom_range(0, b - 1))));
        end
      end
      foreach (digs[i]) txt.push_back(digs[i]);
    end
    if (txt.size() == 0 || $urandom_range(0, 11) != 0) begin
      do c = 8'($urandom_range(0, 255)); while (digit_val(c) < b);
      txt.push_back(c);
    end
    foreach (txt[i]) send_beat(txt[i], i == 0);
  endtask

  // Random bytes with a random start flag: junk, restarts and ignored beats.
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset leaves radix 10 and unsigned mode; a minus sign then wraps.
  task automatic test_reset_defaults();
    send_text("  +42", ",");
    send_text("-7", 8'h00);
    settle();
  endtask

  // Prefix detection with automatic and fixed bases, including a prefix
  // with no digit after it and a lone zero.
  task automatic test_prefixes();
    set_mode(ttip_pkg::BASE_AUTO, 1'b0);
    send_text("\t0X7f", "G");
    send_text("0b101", "2");
    send_text("017", "8");
    send_text("0x", "g");
    send_text("-0b", " ");
    send_text("0", 8'h00);
    send_text("\n 19", "a");
    set_mode(ttip_pkg::BASE_HEX, 1'b0);
    send_text("0x1A", "g");
    set_mode(ttip_pkg::BASE_BIN, 1'b0);
    send_text("0B11", 8'h00);
  endtask

  // Inputs that hold no number: lone signs, blanks, junk and bases that
  // accept no digit at all.
  task automatic test_no_number();
    set_mode(ttip_pkg::BASE_DEC, 1'b0);
    send_text("+", 8'h00);
    send_text("-", "-");
    send_text("  ", "q");
    set_mode(6'd1, 1'b0);
    send_text("5", 8'h00);
    set_mode(6'd37, 1'b0);
    send_text("5", 8'h00);
    set_mode('1, 1'b1);
    send_text("z", 8'h00);
  endtask

  // Unsigned limits: the largest value, one past it, and digits that keep
  // coming after the magnitude has overflowed.
  task automatic test_unsigned_overflow();
    set_mode(ttip_pkg::BASE_DEC, 1'b0);
    send_text("18446744073709551615", " ");
    send_text("18446744073709551616", " ");
    send_text("-1", 8'h00);
    send_text("99999999999999999999999", 8'h00);
  endtask

  // Signed limits on both sides, exactly at and just past them.
  task automatic test_signed_limits();
    set_mode(ttip_pkg::BASE_HEX, 1'b1);
    send_text("7fffffffffffffff", 8'h00);
    send_text("8000000000000000", 8'h00);
    send_text("-8000000000000000", 8'h00);
    send_text("-8000000000000001", 8'h00);
    send_text("-0", 8'h00);
    set_mode(ttip_pkg::BASE_MAX, 1'b1);
    send_text("ZZZZZZZZZZZZZZ", 8'h00);
  endtask

  // A character without start while idle is ignored; a start in the middle
  // of a conversion drops it without a result.
  task automatic test_idle_and_restart();
    set_mode(ttip_pkg::BASE_DEC, 1'b0);
    send_beat("9", 1'b0);
    send_beat("1", 1'b1);
    send_beat("2", 1'b0);
    send_beat("3", 1'b1);
    send_beat("4", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat("0", 1'b1);
    send_beat("x", 1'b1);
    send_beat("7", 1'b1);
    send_beat(".", 1'b0);
    settle();
  endtask

  // A long run of blanks and leading zeros before the one significant digit.
  task automatic test_long_input();
    set_mode(ttip_pkg::BASE_DEC, 1'b0);
    send_beat(ttip_pkg::CH_SPACE, 1'b1);
    repeat (29) send_beat(ttip_pkg::CH_SPACE, 1'b0);
    repeat (40) send_beat(ttip_pkg::CH_ZERO, 1'b0);
    send_beat("5", 1'b0);
    send_beat(8'h00, 1'b0);
    settle();
  endtask

  // Random conversions over several register settings. Once, midway, the
  // sender holds off until every result is out.
  task automatic test_random_streams();
    logic [ttip_pkg::BASE_W-1:0] rdx;
    int                          target;
    bit                          held = 1'b0;
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 9))
        0, 1:    rdx = ttip_pkg::BASE_AUTO;
        2:       rdx = ttip_pkg::BASE_BIN;
        3:       rdx = ttip_pkg::BASE_OCT;
        4:       rdx = ttip_pkg::BASE_DEC;
        5:       rdx = ttip_pkg::BASE_HEX;
        6:       rdx = ttip_pkg::BASE_MAX;
        7, 8:    rdx = ttip_pkg::BASE_W'($urandom_range(2, 36));
        default: rdx = $urandom_range(0, 1) ? 6'd1 : ttip_pkg::BASE_W'($urandom_range(37, 63));
      endcase
      set_mode(rdx, 1'($urandom_range(0, 1)));
      target = live_beats + 55;
      while (live_beats < target) begin
        if ($urandom_range(0, 9) < 8) send_number();
        else send_noise();
        if (!held && p == 3 && live_beats >= target - 30) begin
          wait_drained();
          held = 1'b1;
        end
      end
    end
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_prefixes();
    test_no_number();
    test_unsigned_overflow();
    test_signed_limits();
    test_idle_and_restart();
    test_long_input();
    test_random_streams();
    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: a time limit far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
